// ----- rtl/tesc_pkg.sv -----
// ----------------------------------------------------------------------------
// tesc_pkg: terminal escape to scancode shared definitions
// Phase codes, character codes, the scan code table and the key decoders.
// ----------------------------------------------------------------------------
package tesc_pkg;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_ESC  = 2'd1,
		PH_CSI  = 2'd2,
		PH_SS   = 2'd3
	} phase_t;

	localparam logic [7:0]  CH_ESC    = 8'h1b;
	localparam logic [7:0]  CH_DEL    = 8'h7f;
	localparam logic [7:0]  CH_LBRACK = 8'h5b;
	localparam logic [7:0]  CH_TILDE  = 8'h7e;
	localparam logic [7:0]  CH_SS3    = 8'h4f;
	localparam logic [15:0] KEY_DEL   = 16'h5300;
	localparam logic [15:0] KEY_ESC   = 16'h001b;
	localparam logic [15:0] GAP_RESET = 16'd100;
	localparam logic [2:0]  SEQ_KEEP  = 3'd3;
	localparam logic [2:0]  SEQ_MAX   = 3'd7;

	typedef struct packed {
		logic       step;
		logic       mode;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic        hit;
		logic [15:0] key_code;
	} res_t;

	localparam logic [7:0] SCAN_ROM [128] = '{
		8'h00,8'h1E,8'h30,8'h2E,8'h20,8'h12,8'h21,8'h22,
		8'h23,8'h17,8'h24,8'h25,8'h26,8'h32,8'h31,8'h18,
		8'h19,8'h10,8'h13,8'h1F,8'h14,8'h16,8'h2F,8'h11,
		8'h2D,8'h15,8'h2C,8'h00,8'h00,8'h00,8'h00,8'h00,
		8'h00,8'h02,8'h00,8'h04,8'h05,8'h06,8'h08,8'h00,
		8'h0A,8'h0B,8'h09,8'h00,8'h00,8'h00,8'h53,8'h00,
		8'h0B,8'h02,8'h03,8'h04,8'h05,8'h06,8'h07,8'h08,
		8'h09,8'h0A,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
		8'h03,8'h1E,8'h30,8'h2E,8'h20,8'h12,8'h21,8'h22,
		8'h23,8'h17,8'h24,8'h25,8'h26,8'h32,8'h31,8'h18,
		8'h19,8'h10,8'h13,8'h1F,8'h14,8'h16,8'h2F,8'h11,
		8'h2D,8'h15,8'h2C,8'h00,8'h00,8'h00,8'h07,8'h00,
		8'h00,8'h1E,8'h30,8'h2E,8'h20,8'h12,8'h21,8'h22,
		8'h23,8'h17,8'h24,8'h25,8'h26,8'h32,8'h31,8'h18,
		8'h19,8'h10,8'h13,8'h1F,8'h14,8'h16,8'h2F,8'h11,
		8'h2D,8'h15,8'h2C,8'h00,8'h00,8'h00,8'h00,8'h00
	};

	function automatic res_t decode_csi(input logic [2:0] cnt, input logic [7:0] b0,
			input logic [7:0] b1, input logic [7:0] b2);
		res_t r;
		r.hit      = 1'b0;
		r.key_code = 16'h0000;
		if (cnt == 3'd1) begin
			unique case (b0)
				8'h41: begin r.hit = 1'b1; r.key_code = 16'h4800; end
				8'h42: begin r.hit = 1'b1; r.key_code = 16'h5000; end
				8'h43: begin r.hit = 1'b1; r.key_code = 16'h4D00; end
				8'h44: begin r.hit = 1'b1; r.key_code = 16'h4B00; end
				default: r.hit = 1'b0;
			endcase
		end else if (cnt == 3'd2 && b1 == CH_TILDE) begin
			unique case (b0)
				8'h31: begin r.hit = 1'b1; r.key_code = 16'h4700; end
				8'h32: begin r.hit = 1'b1; r.key_code = 16'h5200; end
				8'h34: begin r.hit = 1'b1; r.key_code = 16'h4F00; end
				8'h35: begin r.hit = 1'b1; r.key_code = 16'h4900; end
				8'h36: begin r.hit = 1'b1; r.key_code = 16'h5100; end
				default: r.hit = 1'b0;
			endcase
		end else if (cnt == 3'd3 && b2 == CH_TILDE) begin
			unique case ({b0, b1})
				16'h3131: begin r.hit = 1'b1; r.key_code = 16'h3B00; end
				16'h3132: begin r.hit = 1'b1; r.key_code = 16'h3C00; end
				16'h3133: begin r.hit = 1'b1; r.key_code = 16'h3D00; end
				16'h3134: begin r.hit = 1'b1; r.key_code = 16'h3E00; end
				16'h3135: begin r.hit = 1'b1; r.key_code = 16'h3F00; end
				16'h3137: begin r.hit = 1'b1; r.key_code = 16'h4000; end
				16'h3138: begin r.hit = 1'b1; r.key_code = 16'h4100; end
				16'h3139: begin r.hit = 1'b1; r.key_code = 16'h4200; end
				16'h3230: begin r.hit = 1'b1; r.key_code = 16'h4300; end
				16'h3231: begin r.hit = 1'b1; r.key_code = 16'h4400; end
				16'h3233: begin r.hit = 1'b1; r.key_code = 16'h8500; end
				16'h3234: begin r.hit = 1'b1; r.key_code = 16'h8600; end
				default: r.hit = 1'b0;
			endcase
		end
		return r;
	endfunction

	function automatic res_t decode_ss(input logic [2:0] cnt, input logic [7:0] b0,
			input logic [7:0] b1);
		res_t r;
		r.hit      = 1'b0;
		r.key_code = 16'h0000;
		if (cnt == 3'd2 && b0 == CH_SS3) begin
			unique case (b1)
				8'h51: begin r.hit = 1'b1; r.key_code = 16'h352F; end
				8'h52: begin r.hit = 1'b1; r.key_code = 16'h372A; end
				8'h53: begin r.hit = 1'b1; r.key_code = 16'h4A2D; end
				default: r.hit = 1'b0;
			endcase
		end
		return r;
	endfunction

endpackage

// ----- rtl/tesc_engine.sv -----
// ----------------------------------------------------------------------------
// tesc_engine: escape sequence state and key code decode
// Holds the sequence phase, body bytes and counters, and decodes one item
// per step into at most one key code.
// ----------------------------------------------------------------------------
module tesc_engine
	import tesc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  item_t       item,
	output res_t        res
);

	phase_t      phase_q, phase_d;
	logic [7:0]  seq_q [3];
	logic [2:0]  cnt_q, cnt_d;
	logic [15:0] idle_q, idle_d, idle_inc;
	logic [15:0] gap_q;
	logic        store;
	res_t        csi_r, ss_r;

	assign csi_r    = decode_csi(cnt_q, seq_q[0], seq_q[1], seq_q[2]);
	assign ss_r     = decode_ss(cnt_q, seq_q[0], seq_q[1]);
	assign idle_inc = (idle_q != 16'hFFFF) ? idle_q + 16'd1 : idle_q;

	always_comb begin
		phase_d      = phase_q;
		cnt_d        = cnt_q;
		idle_d       = idle_q;
		store        = 1'b0;
		res.hit      = 1'b0;
		res.key_code = 16'h0000;
		if (item.mode) begin
			if (phase_q != PH_IDLE) begin
				idle_d = idle_inc;
				if (idle_inc >= gap_q) begin
					unique case (phase_q)
						PH_ESC: begin
							res.hit      = 1'b1;
							res.key_code = KEY_ESC;
						end
						PH_CSI:  res = csi_r;
						default: res = ss_r;
					endcase
					phase_d = PH_IDLE;
					cnt_d   = 3'd0;
					idle_d  = 16'd0;
				end
			end
		end else begin
			unique case (phase_q)
				PH_IDLE: begin
					if (item.rx_byte == CH_ESC) begin
						phase_d = PH_ESC;
						cnt_d   = 3'd0;
						idle_d  = 16'd0;
					end else if (item.rx_byte == CH_DEL) begin
						res.hit      = 1'b1;
						res.key_code = KEY_DEL;
					end else begin
						res.hit      = 1'b1;
						res.key_code = {SCAN_ROM[item.rx_byte[6:0]], item.rx_byte};
					end
				end
				PH_ESC: begin
					idle_d = 16'd0;
					if (item.rx_byte == CH_LBRACK) begin
						phase_d = PH_CSI;
						cnt_d   = 3'd0;
					end else begin
						phase_d = PH_SS;
						store   = 1'b1;
						cnt_d   = 3'd1;
					end
				end
				default: begin
					idle_d = 16'd0;
					store  = 1'b1;
					cnt_d  = (cnt_q != SEQ_MAX) ? cnt_q + 3'd1 : cnt_q;
				end
			endcase
		end
		res.hit = res.hit & item.step;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= 3'd0;
			idle_q  <= 16'd0;
			gap_q   <= GAP_RESET;
		end else begin
			if (cfg_we) gap_q <= cfg_wdata;
			if (item.step) begin
				phase_q <= phase_d;
				cnt_q   <= cnt_d;
				idle_q  <= idle_d;
			end
		end
	end

	// body bytes: slot is the count before this byte (zero right after ESC)
	always_ff @(posedge clk) begin
		if (item.step && store) begin
			if (phase_q == PH_ESC) begin
				seq_q[0] <= item.rx_byte;
			end else if (cnt_q < SEQ_KEEP) begin
				seq_q[cnt_q[1:0]] <= item.rx_byte;
			end
		end
	end

	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> cnt_q == 3'd0 && idle_q == 16'd0)
		else $error("idle phase with nonzero counters");
	a_esc_empty: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_ESC |-> cnt_q == 3'd0)
		else $error("body count nonzero right after ESC");
	a_close: assert property (@(posedge clk) disable iff (!arst_n)
		item.step && item.mode && phase_q != PH_IDLE && idle_inc >= gap_q
		|=> phase_q == PH_IDLE)
		else $error("sequence not closed after gap");

endmodule

// ----- rtl/terminal_escape_to_scancode_core.sv -----
// ----------------------------------------------------------------------------
// terminal_escape_to_scancode_core: terminal bytes to PC key codes
// Converts received terminal bytes and idle ticks into 16-bit key codes.
// ----------------------------------------------------------------------------
// Input stream s_axis: tdata carries the received byte, tuser is the item
// kind (0 byte, 1 idle tick; tdata ignored for ticks). Output stream m_axis:
// tdata carries the key code (scan code high byte, character low byte).
// A transfer on s_axis yields zero or one transfer on m_axis; escape
// sequences give their key on the idle tick that closes them.
// The gap length is written through cfg_we/cfg_wdata while the stream is
// quiet; it resets to 100 ticks.
// Each item passes through an input register, then the decode into the output
// register. Throughput is one item per cycle while the receiver keeps up; the
// input register advances whenever the output register is empty or being
// taken, so a stalled receiver holds the result and the input stalls only
// once both registers are full.
// Reset clears the pipeline and returns the decoder to idle with an empty
// sequence.
// ----------------------------------------------------------------------------
module terminal_escape_to_scancode_core
	import tesc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	input  logic        s_axis_tuser,   // [0] mode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata    // [15:0] key_code
);

	logic       valid_s1;
	logic       mode_s1;
	logic [7:0] byte_s1;
	logic       out_valid_q;
	logic [15:0] out_data_q;
	logic       advance;
	item_t      item;
	res_t       res;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			mode_s1 <= s_axis_tuser;
			byte_s1 <= s_axis_tdata;
		end
	end

	assign item.step    = advance;
	assign item.mode    = mode_s1;
	assign item.rx_byte = byte_s1;

	tesc_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.item      (item),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_axis_tready) begin
			out_valid_q <= res.hit;
		end
	end

	always_ff @(posedge clk) begin
		if (res.hit) out_data_q <= res.key_code;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule
